### src/windowed_rms_meter_top_macros.svh
// Assertion macros for the windowed RMS meter.
// Used by the port checker; depends on clk_i and rst_ni being in scope.
`ifndef WINDOWED_RMS_METER_TOP_MACROS_SVH
`define WINDOWED_RMS_METER_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define WRM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define WRM_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/wrm_pkg.sv
// Package for the windowed RMS meter: widths, constants, controller state
// type and the command/status structs between controller and datapath.
`default_nettype none

package wrm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned SUM_W    = 47;
  localparam int unsigned SQ_W     = 34;
  localparam int unsigned QUO_W    = 32;
  localparam int unsigned RMS_W    = 16;
  localparam int unsigned STEP_W   = 6;

  localparam logic [CNT_W-1:0]  WL_RESET  = 16'd8192;
  localparam logic [STEP_W-1:0] DIV_LAST  = 6'd46;
  localparam logic [STEP_W-1:0] ROOT_LAST = 6'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic acc_en;
    logic div_load;
    logic div_step;
    logic root_load;
    logic root_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic win_end;
  } dp_status_t;

endpackage

`default_nettype wire

### src/wrm_datapath.sv
// Datapath of the windowed RMS meter: window register, sum of squares,
// restoring divider, bit-pair square root and output register. Uses wrm_pkg.
`default_nettype none

module wrm_datapath import wrm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CNT_W-1:0]    cfg_wdata_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire ctrl_cmd_t           cmd_i,
  output      dp_status_t          status_o,
  output      logic [RMS_W-1:0]    rms_value_o
);

  logic [CNT_W-1:0]   wl_q;
  logic [SUM_W-1:0]   sum_q, sum_d, sum_new;
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_new, limit;
  logic [SAMPLE_W:0]  mag;
  logic [SQ_W-1:0]    square;

  logic [CNT_W-1:0]   divisor_q;
  logic [CNT_W-1:0]   div_rem_q;
  logic [SUM_W-1:0]   div_sh_q;
  logic [CNT_W:0]     div_trial, div_diff;
  logic               div_ge;

  logic [QUO_W-1:0]   rad_q;
  logic [RMS_W+2:0]   root_rem_q;
  logic [RMS_W-1:0]   root_q;
  logic [RMS_W+2:0]   root_rem_sh, root_trial;
  logic               root_ge;

  logic [RMS_W-1:0]   rms_q;

  // Magnitude of the two's complement sample, 0..32768.
  assign mag     = sample_i[SAMPLE_W-1] ? ((SAMPLE_W+1)'(1) << SAMPLE_W) - {1'b0, sample_i}
                                        : {1'b0, sample_i};
  assign square  = SQ_W'(mag) * SQ_W'(mag);
  assign sum_new = sum_q + SUM_W'(square);
  assign cnt_new = cnt_q + 1'b1;
  assign limit   = (wl_q == '0) ? CNT_W'(1) : wl_q;

  assign status_o.win_end = (cnt_new != '0) && (cnt_new >= limit);

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (cmd_i.acc_en) begin
      if (status_o.win_end) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_new;
        cnt_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q  <= WL_RESET;
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        wl_q <= cfg_wdata_i;
      end
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // One quotient bit per step; the remainder always stays below the divisor.
  assign div_trial = {div_rem_q, div_sh_q[SUM_W-1]};
  assign div_ge    = div_trial >= {1'b0, divisor_q};
  assign div_diff  = div_trial - {1'b0, divisor_q};

  // One root bit per step from the next two radicand bits.
  assign root_rem_sh = {root_rem_q[RMS_W:0], rad_q[QUO_W-1 -: 2]};
  assign root_trial  = {1'b0, root_q, 2'b01};
  assign root_ge     = root_rem_sh >= root_trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      divisor_q <= cnt_new;
      div_rem_q <= '0;
      div_sh_q  <= sum_new;
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
      div_sh_q  <= {div_sh_q[SUM_W-2:0], div_ge};
    end

    if (cmd_i.root_load) begin
      rad_q      <= div_sh_q[QUO_W-1:0];
      root_rem_q <= '0;
      root_q     <= '0;
    end else if (cmd_i.root_step) begin
      rad_q      <= {rad_q[QUO_W-3:0], 2'b00};
      root_rem_q <= root_ge ? (root_rem_sh - root_trial) : root_rem_sh;
      root_q     <= {root_q[RMS_W-2:0], root_ge};
    end

    if (cmd_i.out_load) begin
      rms_q <= root_q;
    end
  end

  assign rms_value_o = rms_q;

endmodule

`default_nettype wire

### src/wrm_ctrl.sv
// Controller of the windowed RMS meter: sequences divide, square root and
// output hand-off, and gates input requests. Uses wrm_pkg.
`default_nettype none

module wrm_ctrl import wrm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       out_ready_i,
  input  wire dp_status_t status_i,
  output      logic       in_ready_o,
  output      logic       out_valid_o,
  output      ctrl_cmd_t  cmd_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (cmd_o.div_load) state_d = ST_DIVIDE;
      ST_DIVIDE:    if (step_q == DIV_LAST) state_d = ST_ROOT_LOAD;
      ST_ROOT_LOAD: state_d = ST_ROOT;
      ST_ROOT:      if (step_q == ROOT_LAST) state_d = ST_DONE;
      ST_DONE:      if (slot_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    step_d         = '0;
    // A request that closes a window waits while the previous one is in work.
    in_ready_o     = !(status_i.win_end && (state_q != ST_IDLE));
    cmd_o.acc_en   = in_valid_i && in_ready_o;
    cmd_o.div_load = cmd_o.acc_en && status_i.win_end;
    unique case (state_q)
      ST_IDLE:      ;
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (step_q != DIV_LAST) step_d = step_q + 1'b1;
      end
      ST_ROOT_LOAD: cmd_o.root_load = 1'b1;
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (step_q != ROOT_LAST) step_d = step_q + 1'b1;
      end
      ST_DONE:      cmd_o.out_load = slot_free;
      default:      ;
    endcase
    out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### src/windowed_rms_meter_top.sv
// Top level of the windowed RMS meter: joins controller and datapath.
// Depends on wrm_pkg, wrm_ctrl and wrm_datapath.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid_i, in_ready_o, sample_i | request in
//   out     | out_valid_o, out_ready_i,        | request out
//           | rms_value_o                      |
//   cfg     | cfg_we_i, cfg_wdata_i            | write only
//
// Samples are taken one per cycle while in_ready_o is high; the square and the sum
// update in the same cycle. A request that closes a window hands sum and count to
// the result engine: 47 divider steps, one load, 16 root steps, one hand-off.
// Accumulation of the next window goes on meanwhile; only a request that would
// close another window stalls while the engine is busy or cannot hand off its result.
// Reset clears the sum, the count and all control state and sets the window to 8192.
`default_nettype none

module windowed_rms_meter_top import wrm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CNT_W-1:0]    cfg_wdata_i,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [RMS_W-1:0]    rms_value_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller owns all handshakes and the step counter.
  wrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // The datapath keeps the window length, the running sum and the result units.
  wrm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .rms_value_o (rms_value_o)
  );

endmodule

`default_nettype wire

### src/wrm_checker.sv
// Port checker for the windowed RMS meter, bound to the top level.
// Depends on windowed_rms_meter_top_macros.svh.
`default_nettype none
`include "windowed_rms_meter_top_macros.svh"

module wrm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] rms_value_o
);

  // A waiting result keeps its value until taken.
  `WRM_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(rms_value_o), "result changed while stalled")

  // The root of a mean of 16-bit squares never exceeds 32768.
  `WRM_ASSERT(a_out_range, out_valid_o |-> rms_value_o <= 16'd32768, "result out of range")

  // Ready only drops after an accepted request or a window change.
  `WRM_ASSERT(a_ready_fall, $fell(in_ready_o) |-> $past((in_valid_i && in_ready_o) || cfg_we_i), "ready dropped without cause")

  // No result is shown during reset, and the block is ready right after it.
  `WRM_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_o, "result valid in reset")
  `WRM_ASSERT_RST(a_rst_ready, $rose(rst_ni) |-> in_ready_o, "not ready after reset")

endmodule

bind windowed_rms_meter_top wrm_checker u_wrm_checker (.*);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for windowed_rms_meter_top: drives sample requests and window
// writes, predicts each RMS result and compares it with what the block returns.
// Depends on wrm_pkg and the windowed_rms_meter_top RTL only.
module testbench;
  import wrm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let pass before a window write, so that any result still in the
  // divide and root engine has cleared.
  localparam int unsigned SETTLE_CYCLES = 80;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b1;
  logic               cfg_we_i = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [SAMPLE_W-1:0] sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [RMS_W-1:0]   rms_value_o;

  // Idle and stall chances, in percent, for the current phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;

  // Predicted state of the meter and the RMS values still to come out.
  logic [SUM_W-1:0]  pred_square_sum;
  logic [CNT_W-1:0]  pred_count;
  logic [CNT_W-1:0]  pred_window;
  logic [RMS_W-1:0]  rms_expected[$];

  windowed_rms_meter_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rms_value_o (rms_value_o)
  );

  always #10 clk_i = ~clk_i;

  // Floor square root, found one result bit at a time from the top down: a bit
  // is kept when the trial root squared still fits under the value.
  function automatic logic [RMS_W-1:0] floor_root(input logic [SUM_W-1:0] value);
    logic [63:0] root;
    logic [63:0] trial;
    root = 0;
    for (int b = RMS_W; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= 64'(value)) begin
        root = trial;
      end
    end
    return root[RMS_W-1:0];
  endfunction

  // Adds one accepted sample to the predicted window. When the count reaches
  // the window length (zero counts as one), the mean is taken over the samples
  // actually seen, which matters when the window was shortened mid-window.
  task automatic account_sample(input logic [SAMPLE_W-1:0] raw);
    logic [SUM_W-1:0] magnitude;
    logic [CNT_W-1:0] limit;
    magnitude = raw[SAMPLE_W-1] ? SUM_W'(17'h10000 - 17'(raw)) : SUM_W'(raw);
    pred_square_sum = pred_square_sum + magnitude * magnitude;
    pred_count = pred_count + 1'b1;
    limit = (pred_window == 0) ? CNT_W'(1) : pred_window;
    if (pred_count != 0 && pred_count >= limit) begin
      rms_expected.push_back(floor_root(pred_square_sum / SUM_W'(pred_count)));
      pred_square_sum = '0;
      pred_count = '0;
    end
  endtask

  // Watches both request channels and the register port at the rising edge.
  // Inputs only move at the falling edge, so the values read here are stable.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_square_sum = '0;
      pred_count = '0;
      pred_window = WL_RESET;
    end else begin
      if (cfg_we_i) begin
        pred_window = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_o) begin
        account_sample(sample_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (rms_expected.size() == 0) begin
          $error("unexpected result: rms_value actual %0d", rms_value_o);
          errors++;
        end else begin
          if (rms_value_o !== rms_expected[0]) begin
            $error("rms_value mismatch: expected %0d actual %0d",
                   rms_expected[0], rms_value_o);
            errors++;
          end
          void'(rms_expected.pop_front());
        end
      end
    end
  end

  // The receiver drops ready at random, as often as the phase asks.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one sample request, with random idle cycles ahead of it. Valid is
  // left high on return so back-to-back requests never drop it in between;
  // it is lowered only in an idle cycle or when the stream is drained.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i = value;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Stops the stream, waits for every outstanding result, then lets the
  // engine settle so the block is idle.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (rms_expected.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [CNT_W-1:0] length);
    drain_results();
    cfg_we_i = 1'b1;
    cfg_wdata_i = length;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mix of extremes, small values and the full 16-bit range.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return $urandom_range(1) ? 16'h0001 : 16'hFFFF;
      4, 5: return SAMPLE_W'($urandom_range(510) - 255);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // After reset the window must be 8192, so a few samples give no result.
  // Writing a window equal to the count then lets the next sample close it
  // over four samples.
  task automatic test_default_window();
    send_sample(16'd300);
    send_sample(16'hFED4);
    send_sample(16'd7);
    write_window(16'd3);
    send_sample(16'h8000);
  endtask

  // Full-scale windows: the most negative sample gives the top result 32768.
  task automatic test_full_scale();
    write_window(16'd4);
    repeat (4) send_sample(16'h8000);
    repeat (4) send_sample(16'h7FFF);
  endtask

  // A zero window behaves as one, so every sample makes a result.
  task automatic test_zero_window();
    write_window(16'd0);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
  endtask

  // Largest window, then a shortened one: the sum passes 32 bits before the
  // window is closed by the next sample.
  task automatic test_wide_sum();
    write_window(16'hFFFF);
    repeat (3) send_sample(16'h8000);
    repeat (3) send_sample(16'h7FFF);
    write_window(16'd2);
    send_sample(16'h8000);
  endtask

  // Random segments: each picks a window and mostly sends whole windows of
  // random samples; the rest are ragged lengths that leave a partial window
  // behind for the next window write to cut short.
  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned n_items);
    int unsigned sent;
    int unsigned length;
    int unsigned roll;
    logic [CNT_W-1:0] window;
    logic [CNT_W-1:0] limit;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        window = CNT_W'($urandom_range(8, 1));
      end else if (roll < 85) begin
        window = CNT_W'($urandom_range(40, 9));
      end else if (roll < 90) begin
        window = '0;
      end else if (roll < 95) begin
        window = 16'hFFFF;
      end else begin
        window = CNT_W'($urandom_range(65535, 41));
      end
      write_window(window);
      limit = (window == 0) ? CNT_W'(1) : window;
      if ($urandom_range(9) < 8 && limit <= 40) begin
        length = limit * $urandom_range(3, 1);
      end else begin
        length = $urandom_range(40, 1);
      end
      repeat (length) send_sample(pick_sample());
      sent += length;
    end
    drain_results();
  endtask

  initial begin
    // Reset is applied just after time zero so that the asynchronous reset
    // sees a real falling edge before the first clock edge.
    #1;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_default_window();
    test_full_scale();
    test_zero_window();
    test_wide_sum();

    // Phases of flow control: none, a slow sender, a slow receiver, both.
    test_random_phase(0, 0, 425);
    test_random_phase(74, 0, 425);
    test_random_phase(0, 74, 425);
    test_random_phase(24, 24, 425);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
